// ===== rtl/sqdws_pkg.sv =====
// ----------------------------------------------------------------------------
// sqdws_pkg
// Types and constants for the shortest-queue dispatcher with wait statistics.
// ----------------------------------------------------------------------------
package sqdws_pkg;

    localparam int MAX_SERVERS = 8;
    localparam int QUEUE_DEPTH = 16;

    localparam int SRV_W   = $clog2(MAX_SERVERS);
    localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W  = SRV_W + SLOT_W;
    localparam int STORE_N = MAX_SERVERS * QUEUE_DEPTH;

    localparam int TIME_W  = 24;
    localparam int WORK_W  = 16;
    localparam int TOTAL_W = 40;
    localparam int COUNT_W = 24;
    localparam int JOB_W   = TIME_W + WORK_W;

    localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SERVERS_IN_USE = 2'd0,
        CFG_QUEUE_LIMIT    = 2'd1,
        CFG_TIME_LIMIT     = 2'd2,
        CFG_UNUSED         = 2'd3
    } cfg_index_t;

    localparam logic [3:0]        SERVERS_RESET    = 4'd5;
    localparam logic [4:0]        QLIMIT_RESET     = 5'd5;
    localparam logic [TIME_W-1:0] TIME_LIMIT_RESET = 24'd100000;

    typedef enum logic {
        MODE_ARRIVAL = 1'b0,
        MODE_SERVICE = 1'b1
    } mode_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic        mode;
        logic [15:0] gap_ms;
        logic [15:0] work_ms;
        logic [2:0]  server_sel;
    } in_item_t;

    typedef struct packed {
        logic        accepted;
        logic        dropped;
        logic [2:0]  chosen_server;
        logic        run_stopped;
        logic        job_served;
        logic [23:0] job_wait_ms;
        logic [39:0] wait_total;
        logic [39:0] service_total;
        logic [23:0] served_count;
    } out_item_t;

endpackage

// ===== rtl/shortest_queue_dispatch_with_wait_stats.sv =====
// ----------------------------------------------------------------------------
// shortest_queue_dispatch_with_wait_stats
// Join-shortest-queue job dispatcher with per-server FIFOs and wait totals.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_item carry one item: an arrival (gap and work time) or
//   a service request for one server. Every item yields exactly one result on
//   m_valid/m_ready/m_item, holding the dispatch or pop outcome and the
//   current saturating totals.
//   cfg_valid/cfg_ready/cfg_index/cfg_data writes the server count, queue
//   limit and time limit; cfg_ready is always high. Write only while idle.
//   An accepted item is registered, and its result is written to the output
//   register in the execute cycle; no new item is taken until that ends.
//   The job store is a synchronous RAM; a service item issues its head read
//   at acceptance and finishes in the execute cycle that follows.
//   The output register parts the channels: the next item is accepted while
//   a result waits. If the receiver stalls with a result still held, the
//   execute cycle waits and the input side stops after one more item.
//   Reset clears the clock, stop flag, queue pointers, fills, next-start
//   times and totals, and loads the register defaults. Job store contents
//   need no clearing: only written entries are ever used.
// ----------------------------------------------------------------------------
module shortest_queue_dispatch_with_wait_stats (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sqdws_pkg::in_item_t  s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sqdws_pkg::out_item_t m_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [23:0]          cfg_data
);
    import sqdws_pkg::*;

    // configuration
    logic [3:0]        servers_reg;
    logic [4:0]        qlimit_reg;
    logic [TIME_W-1:0] time_limit_reg;

    // control and per-server state
    state_t             state_reg, state_next;
    logic               stop_reg;
    logic [TIME_W-1:0]  clock_reg;
    logic [FILL_W-1:0]  fill_reg  [MAX_SERVERS];
    logic [TIME_W-1:0]  start_reg [MAX_SERVERS];
    logic [SLOT_W-1:0]  head_reg  [MAX_SERVERS];
    logic [SLOT_W-1:0]  tail_reg  [MAX_SERVERS];
    logic [TOTAL_W-1:0] wait_sum_reg;
    logic [TOTAL_W-1:0] service_sum_reg;
    logic [COUNT_W-1:0] count_reg;

    in_item_t  item_reg;
    out_item_t out_reg;
    logic      out_valid_reg;

    // job store
    logic [JOB_W-1:0]  job_mem [STORE_N];
    logic [JOB_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [JOB_W-1:0]  wr_data;
    logic              wr_en;

    logic s_fire;
    logic exec_fire;

    // execute-cycle results
    logic [TIME_W-1:0]  clock_next;
    logic               stop_next;
    logic [3:0]         n_eff;
    logic [4:0]         lim_eff;
    logic [SRV_W-1:0]   best;
    logic [FILL_W-1:0]  best_fill;
    logic [SRV_W-1:0]   sel;
    logic               do_push;
    logic               do_pop;
    logic [TIME_W-1:0]  arr_time;
    logic [WORK_W-1:0]  job_work;
    logic [TIME_W-1:0]  wait_ms;
    logic [TIME_W:0]    clock_sum;
    logic [TIME_W:0]    start_sum;
    logic [TIME_W-1:0]  start_pop;
    logic [TOTAL_W:0]   wait_sum_wide;
    logic [TOTAL_W:0]   service_sum_wide;
    logic [TOTAL_W-1:0] wait_sum_next;
    logic [TOTAL_W-1:0] service_sum_next;
    logic [COUNT_W-1:0] count_next;
    out_item_t          out_next;

    // ------------------------------------------------------------------
    // FSM
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!out_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        exec_fire = (state_reg == ST_EXEC) && (!out_valid_reg || m_ready);
    end

    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_item    = out_reg;

    // ------------------------------------------------------------------
    // Job store: read head at acceptance, write tail in the execute cycle
    // ------------------------------------------------------------------
    assign rd_addr = {s_item.server_sel[SRV_W-1:0], head_reg[s_item.server_sel[SRV_W-1:0]]};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            job_mem[wr_addr] <= wr_data;
        end
        if (s_fire) begin
            rd_data_reg <= job_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Execute datapath
    // ------------------------------------------------------------------
    always_comb begin
        n_eff = servers_reg;
        if (servers_reg == 4'd0) begin
            n_eff = 4'd1;
        end else if (32'(servers_reg) > MAX_SERVERS) begin
            n_eff = 4'(MAX_SERVERS);
        end
        lim_eff = qlimit_reg;
        if (32'(qlimit_reg) > QUEUE_DEPTH) begin
            lim_eff = 5'(QUEUE_DEPTH);
        end
    end

    // shortest active queue, lowest index wins a tie
    always_comb begin
        best      = '0;
        best_fill = fill_reg[0];
        for (int i = 1; i < MAX_SERVERS; i++) begin
            if (i < 32'(n_eff) && fill_reg[i] < best_fill) begin
                best      = SRV_W'(i);
                best_fill = fill_reg[i];
            end
        end
    end

    always_comb begin
        sel       = item_reg.server_sel[SRV_W-1:0];
        clock_sum = {1'b0, clock_reg} + {{(TIME_W + 1 - WORK_W){1'b0}}, item_reg.gap_ms};
        arr_time  = rd_data_reg[JOB_W-1:WORK_W];
        job_work  = rd_data_reg[WORK_W-1:0];

        clock_next = clock_reg;
        stop_next  = stop_reg;
        do_push    = 1'b0;
        do_pop     = 1'b0;
        out_next   = '0;

        if (!stop_reg && item_reg.mode == MODE_ARRIVAL) begin
            clock_next = clock_sum[TIME_W] ? TIME_MAX : clock_sum[TIME_W-1:0];
            if (clock_next > time_limit_reg) begin
                stop_next = 1'b1;
            end else begin
                out_next.chosen_server = 3'(best);
                if (32'(best_fill) < 32'(lim_eff)) begin
                    do_push           = 1'b1;
                    out_next.accepted = 1'b1;
                end else begin
                    out_next.dropped = 1'b1;
                end
            end
        end else if (!stop_reg) begin
            out_next.chosen_server = item_reg.server_sel;
            if (32'(item_reg.server_sel) < MAX_SERVERS && fill_reg[sel] != '0) begin
                do_pop = 1'b1;
            end
        end

        wait_ms = (do_pop && start_reg[sel] > arr_time) ? start_reg[sel] - arr_time : '0;

        wait_sum_wide    = {1'b0, wait_sum_reg}
                         + {{(TOTAL_W + 1 - TIME_W){1'b0}}, wait_ms};
        service_sum_wide = {1'b0, service_sum_reg}
                         + {{(TOTAL_W + 1 - WORK_W){1'b0}}, job_work};
        start_sum        = {1'b0, start_reg[sel]} + {{(TIME_W + 1 - WORK_W){1'b0}}, job_work};
        start_pop        = start_sum[TIME_W] ? TIME_MAX : start_sum[TIME_W-1:0];

        wait_sum_next    = wait_sum_reg;
        service_sum_next = service_sum_reg;
        count_next       = count_reg;
        if (do_pop) begin
            wait_sum_next    = wait_sum_wide[TOTAL_W] ? TOTAL_MAX : wait_sum_wide[TOTAL_W-1:0];
            service_sum_next = service_sum_wide[TOTAL_W] ? TOTAL_MAX
                                                         : service_sum_wide[TOTAL_W-1:0];
            count_next       = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 1'b1;
        end

        out_next.run_stopped   = stop_next;
        out_next.job_served    = do_pop;
        out_next.job_wait_ms   = wait_ms;
        out_next.wait_total    = wait_sum_next;
        out_next.service_total = service_sum_next;
        out_next.served_count  = count_next;

        wr_en   = exec_fire && do_push;
        wr_addr = {best, tail_reg[best]};
        wr_data = {clock_next, item_reg.work_ms};
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg <= s_item;
        end
        if (exec_fire) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            servers_reg    <= SERVERS_RESET;
            qlimit_reg     <= QLIMIT_RESET;
            time_limit_reg <= TIME_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SERVERS_IN_USE: servers_reg    <= cfg_data[3:0];
                CFG_QUEUE_LIMIT:    qlimit_reg     <= cfg_data[4:0];
                CFG_TIME_LIMIT:     time_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            stop_reg        <= 1'b0;
            clock_reg       <= '0;
            wait_sum_reg    <= '0;
            service_sum_reg <= '0;
            count_reg       <= '0;
            for (int i = 0; i < MAX_SERVERS; i++) begin
                fill_reg[i]  <= '0;
                start_reg[i] <= '0;
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (exec_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (exec_fire) begin
                stop_reg        <= stop_next;
                clock_reg       <= clock_next;
                wait_sum_reg    <= wait_sum_next;
                service_sum_reg <= service_sum_next;
                count_reg       <= count_next;
                if (do_push) begin
                    fill_reg[best] <= fill_reg[best] + 1'b1;
                    tail_reg[best] <= (32'(tail_reg[best]) == QUEUE_DEPTH - 1)
                                    ? '0 : tail_reg[best] + 1'b1;
                    if (start_reg[best] < clock_next) begin
                        start_reg[best] <= clock_next;
                    end
                end
                if (do_pop) begin
                    fill_reg[sel]  <= fill_reg[sel] - 1'b1;
                    head_reg[sel]  <= (32'(head_reg[sel]) == QUEUE_DEPTH - 1)
                                    ? '0 : head_reg[sel] + 1'b1;
                    start_reg[sel] <= start_pop;
                end
            end
        end
    end

endmodule
